// ----- rtl/keyed_secret_table_defines.svh -----
// Assertion macros shared by the keyed secret table RTL.
`ifndef KEYED_SECRET_TABLE_DEFINES_SVH
`define KEYED_SECRET_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define KST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed_secret_table: same-cycle check failed");
// Next-cycle implication check.
`define KST_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed_secret_table: next-cycle check failed");
`else
`define KST_ASSERT_IMP(label, clk, rst, ante, cons)
`define KST_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/kst_pkg.sv -----
// Shared constants, codes and types of the keyed secret table.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

   localparam int TABLE_DEPTH  = 64;
   localparam int ID_BITS      = 64;
   localparam int PAYLOAD_BITS = 64;

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

   localparam int CFG_BITS       = 7;
   localparam int ID_PORT_BITS   = 64;
   localparam int DATA_PORT_BITS = 64;
   localparam int KEY_BITS       = 32;
   localparam int STATUS_BITS    = 8;
   localparam int SLOT_BITS      = 6;
   localparam int KIND_BITS      = 2;
   localparam int OUTCOME_BITS   = 2;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

   localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd3;

   localparam logic [OUTCOME_BITS-1:0] OUTCOME_NONE      = 2'd0;
   localparam logic [OUTCOME_BITS-1:0] OUTCOME_UPDATED   = 2'd1;
   localparam logic [OUTCOME_BITS-1:0] OUTCOME_FILLED    = 2'd2;
   localparam logic [OUTCOME_BITS-1:0] OUTCOME_OVERWROTE = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_USABLE = 8'd1;
   localparam logic [KEY_BITS-1:0]    KEY_NOT_FOUND = 32'hFFFF_FFFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic [KIND_BITS-1:0]    op;
      logic                    do_scan;
      logic [CNT_BITS-1:0]     count;
      logic [ID_BITS-1:0]      client_id;
      logic [ID_BITS-1:0]      server_id;
      logic [KEY_BITS-1:0]     key_id;
      logic [STATUS_BITS-1:0]  status;
      logic [PAYLOAD_BITS-1:0] payload;
   } cmd_type;

   // One stored record.
   typedef struct packed {
      logic [ID_BITS-1:0]      client_id;
      logic [ID_BITS-1:0]      server_id;
      logic [KEY_BITS-1:0]     key_id;
      logic [STATUS_BITS-1:0]  status;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic                 full;
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- rtl/kst_front.sv -----
// Request decode: masks the fields and decides whether a table scan is needed.
`timescale 1ns / 1ps
`default_nettype none

module kst_front import kst_pkg::*; (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KIND_BITS-1:0]      req_kind,
   input  logic [ID_PORT_BITS-1:0]   req_client_id,
   input  logic [ID_PORT_BITS-1:0]   req_server_id,
   input  logic signed [KEY_BITS-1:0] req_new_key_id,
   input  logic [STATUS_BITS-1:0]    req_new_status,
   input  logic [DATA_PORT_BITS-1:0] req_new_key_data,
   input  logic [CFG_BITS-1:0]       entries_in_use,
   output logic                      push_valid,
   input  logic                      push_ready,
   output cmd_type                   push_cmd
);

   logic [CNT_BITS-1:0] count;
   logic                ids_present;

   always_comb begin
      if (int'(entries_in_use) > TABLE_DEPTH) begin
         count = CNT_BITS'(TABLE_DEPTH);
      end else begin
         count = CNT_BITS'(entries_in_use);
      end
   end

   always_comb begin
      push_cmd.count     = count;
      push_cmd.client_id = req_client_id[ID_BITS-1:0];
      push_cmd.server_id = req_server_id[ID_BITS-1:0];
      push_cmd.key_id    = req_new_key_id;
      push_cmd.status    = req_new_status;
      push_cmd.payload   = req_new_key_data[PAYLOAD_BITS-1:0];
      ids_present = (push_cmd.client_id != '0) && (push_cmd.server_id != '0);
      // Only writes and reads with both ids present need the table walk.
      case (req_kind)
         KIND_WRITE: begin
            push_cmd.op      = KIND_WRITE;
            push_cmd.do_scan = (count != '0);
         end
         KIND_READ: begin
            push_cmd.op      = KIND_READ;
            push_cmd.do_scan = (count != '0) && ids_present;
         end
         KIND_CLEAR: begin
            push_cmd.op      = KIND_CLEAR;
            push_cmd.do_scan = 1'b0;
         end
         default: begin
            push_cmd.op      = KIND_NONE;
            push_cmd.do_scan = 1'b0;
         end
      endcase
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

// ----- rtl/kst_queue.sv -----
// Small request queue between the decode front and the scan engine.
`timescale 1ns / 1ps
`default_nettype none

module kst_queue import kst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cmd_type          push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cmd_type          pop_cmd,
   output queue_status_type status
);

   cmd_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   assign status.full  = !push_ready;
   assign status.count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/kst_back.sv -----
// Scan engine: walks the record memory, updates it and registers the response.
`timescale 1ns / 1ps
`default_nettype none

module kst_back import kst_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  cmd_type                    cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic signed [KEY_BITS-1:0] rsp_key_id,
   output logic [STATUS_BITS-1:0]     rsp_key_status,
   output logic [DATA_PORT_BITS-1:0]  rsp_key_data,
   output logic [OUTCOME_BITS-1:0]    rsp_write_outcome,
   output logic [SLOT_BITS-1:0]       rsp_slot
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Record memory; a cleared bit in valid_ff makes its entry read as all zero.
   entry_type              store_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic [1:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                issue_done_ff, issue_done_in;
   logic                pend_ff, pend_in;
   logic [IDX_BITS-1:0] pend_idx_ff, pend_idx_in;
   entry_type           rd_entry_ff;
   logic                rd_valid_ff;
   logic                hit_ff, hit_in;
   logic [IDX_BITS-1:0] hit_idx_ff, hit_idx_in;
   entry_type           hit_entry_ff, hit_entry_in;
   logic                empty_seen_ff, empty_seen_in;
   logic [IDX_BITS-1:0] empty_idx_ff, empty_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                      rsp_found_ff, rsp_found_in;
   logic [KEY_BITS-1:0]       rsp_key_id_ff, rsp_key_id_in;
   logic [STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [DATA_PORT_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [OUTCOME_BITS-1:0]   rsp_outcome_ff, rsp_outcome_in;
   logic [SLOT_BITS-1:0]      rsp_slot_ff, rsp_slot_in;

   entry_type           eff_entry;
   logic [IDX_BITS-1:0] last_idx;
   logic                id_equal, write_match, read_match, entry_empty, hit_now;
   logic                rd_en, wr_en, clr_en, rsp_load;
   logic [IDX_BITS-1:0] wr_idx;
   logic [OUTCOME_BITS-1:0] wr_outcome;
   entry_type           wr_entry;

   assign last_idx  = IDX_BITS'(cmd_ff.count - CNT_BITS'(1));
   assign eff_entry = rd_valid_ff ? rd_entry_ff : '0;

   assign id_equal    = (eff_entry.client_id == cmd_ff.client_id) &&
                        (eff_entry.server_id == cmd_ff.server_id);
   assign entry_empty = (eff_entry.client_id == '0) && (eff_entry.server_id == '0);
   assign write_match = id_equal && (eff_entry.client_id != '0) &&
                        (eff_entry.server_id != '0);
   assign read_match  = id_equal && (eff_entry.status == STATUS_USABLE);
   assign hit_now     = pend_ff && ((cmd_ff.op == KIND_WRITE) ? write_match : read_match);

   // Write target: a matching record, else the first empty one, else the last in use.
   always_comb begin
      if (hit_ff) begin
         wr_idx     = hit_idx_ff;
         wr_outcome = OUTCOME_UPDATED;
      end else if (empty_seen_ff) begin
         wr_idx     = empty_idx_ff;
         wr_outcome = OUTCOME_FILLED;
      end else begin
         wr_idx     = last_idx;
         wr_outcome = OUTCOME_OVERWROTE;
      end
   end

   assign wr_entry.client_id = cmd_ff.client_id;
   assign wr_entry.server_id = cmd_ff.server_id;
   assign wr_entry.key_id    = cmd_ff.key_id;
   assign wr_entry.status    = cmd_ff.status;
   assign wr_entry.payload   = cmd_ff.payload;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      issue_done_in  = issue_done_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_entry_in   = hit_entry_ff;
      empty_seen_in  = empty_seen_ff;
      empty_idx_in   = empty_idx_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_key_id_in  = rsp_key_id_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      cmd_ready      = 1'b0;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      clr_en         = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in        = cmd;
               idx_in        = '0;
               issue_done_in = 1'b0;
               pend_in       = 1'b0;
               hit_in        = 1'b0;
               empty_seen_in = 1'b0;
               state_in      = cmd.do_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle, check the previous one's data alongside.
            if (!issue_done_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               if (idx_ff == last_idx) begin
                  issue_done_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (entry_empty && !empty_seen_ff) begin
                  empty_seen_in = 1'b1;
                  empty_idx_in  = pend_idx_ff;
               end
               if (hit_now) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = pend_idx_ff;
                  hit_entry_in = eff_entry;
               end
               if (hit_now || (pend_idx_ff == last_idx)) begin
                  pend_in  = 1'b0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load       = 1'b1;
               state_in       = ST_IDLE;
               rsp_found_in   = 1'b0;
               rsp_key_id_in  = KEY_NOT_FOUND;
               rsp_status_in  = '0;
               rsp_data_in    = '0;
               rsp_outcome_in = OUTCOME_NONE;
               rsp_slot_in    = '0;
               case (cmd_ff.op)
                  KIND_WRITE: begin
                     if (cmd_ff.do_scan) begin
                        wr_en          = 1'b1;
                        rsp_outcome_in = wr_outcome;
                        rsp_slot_in    = SLOT_BITS'(wr_idx);
                     end
                  end
                  KIND_READ: begin
                     if (hit_ff) begin
                        rsp_found_in  = 1'b1;
                        rsp_key_id_in = hit_entry_ff.key_id;
                        rsp_status_in = hit_entry_ff.status;
                        rsp_data_in   = DATA_PORT_BITS'(hit_entry_ff.payload);
                        rsp_slot_in   = SLOT_BITS'(hit_idx_ff);
                     end
                  end
                  KIND_CLEAR: begin
                     clr_en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         empty_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         hit_ff        <= hit_in;
         empty_seen_ff <= empty_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (clr_en) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      pend_idx_ff    <= pend_idx_in;
      hit_idx_ff     <= hit_idx_in;
      hit_entry_ff   <= hit_entry_in;
      empty_idx_ff   <= empty_idx_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_key_id_ff  <= rsp_key_id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= store_ff[idx_ff];
         rd_valid_ff <= valid_ff[idx_ff];
      end
      if (wr_en) begin
         store_ff[wr_idx] <= wr_entry;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_key_id        = rsp_key_id_ff;
   assign rsp_key_status    = rsp_status_ff;
   assign rsp_key_data      = rsp_data_ff;
   assign rsp_write_outcome = rsp_outcome_ff;
   assign rsp_slot          = rsp_slot_ff;

endmodule

`default_nettype wire

// ----- rtl/keyed_secret_table.sv -----
// Top level of the keyed secret table: decode front, request queue and scan engine.
//
//   Port group   Direction   Handshake              Carries
//   req_*        in          req_valid/req_ready    one request: kind, ids, new record
//   rsp_*        out         rsp_valid/rsp_ready    one response per request
//   csr_*        in          csr_valid/csr_ready    entries_in_use register write
//
// A write, or a read with both ids present, walks the entries in use one per cycle
// through the single read port; a match ends the walk early. Clears, reads with an
// empty id and unknown kinds skip the walk. Reset is synchronous and empties every
// entry at once through per-entry valid bits, as a clear request does. A stalled
// response holds in its output register while the engine takes the next request;
// the queue in front takes requests until it fills.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_secret_table_defines.svh"

module keyed_secret_table import kst_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_BITS-1:0]       req_kind,
   input  logic [ID_PORT_BITS-1:0]    req_client_id,
   input  logic [ID_PORT_BITS-1:0]    req_server_id,
   input  logic signed [KEY_BITS-1:0] req_new_key_id,
   input  logic [STATUS_BITS-1:0]     req_new_status,
   input  logic [DATA_PORT_BITS-1:0]  req_new_key_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic signed [KEY_BITS-1:0] rsp_key_id,
   output logic [STATUS_BITS-1:0]     rsp_key_status,
   output logic [DATA_PORT_BITS-1:0]  rsp_key_data,
   output logic [OUTCOME_BITS-1:0]    rsp_write_outcome,
   output logic [SLOT_BITS-1:0]       rsp_slot,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_BITS-1:0]        csr_entries_in_use
);

   // The count register is always writable; software must change it only when idle.
   logic [CFG_BITS-1:0] entries_in_use_ff;

   logic             push_valid, push_ready;
   cmd_type          push_cmd;
   logic             pop_valid, pop_ready;
   cmd_type          pop_cmd;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         entries_in_use_ff <= csr_entries_in_use;
      end
   end

   // Front: decodes each request and computes the saturated entry count.
   kst_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_client_id    (req_client_id),
      .req_server_id    (req_server_id),
      .req_new_key_id   (req_new_key_id),
      .req_new_status   (req_new_status),
      .req_new_key_data (req_new_key_data),
      .entries_in_use   (entries_in_use_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_cmd         (push_cmd)
   );

   // Queue: decouples request intake from the long table walks.
   kst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .status     (q_status)
   );

   // Back: owns the record memory and produces one response per request.
   kst_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (pop_valid),
      .cmd_ready         (pop_ready),
      .cmd               (pop_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_key_id        (rsp_key_id),
      .rsp_key_status    (rsp_key_status),
      .rsp_key_data      (rsp_key_data),
      .rsp_write_outcome (rsp_write_outcome),
      .rsp_slot          (rsp_slot)
   );

   // A full queue must hold off new requests.
   `KST_ASSERT_IMP(a_full_blocks_req, clock, reset, q_status.full, !req_ready)
   // A request into the last free place with no pop fills the queue.
   `KST_ASSERT_NXT(a_queue_fills, clock, reset,
      req_valid && req_ready && !(pop_valid && pop_ready) &&
      q_status.count == QCNT_BITS'(QUEUE_DEPTH - 1),
      q_status.full)
   // A hit always carries a usable record and never a write outcome.
   `KST_ASSERT_IMP(a_hit_is_usable, clock, reset, rsp_valid && rsp_found,
      rsp_key_status == STATUS_USABLE && rsp_write_outcome == OUTCOME_NONE)
   // A write response never reports a found record.
   `KST_ASSERT_IMP(a_write_not_found, clock, reset,
      rsp_valid && rsp_write_outcome != OUTCOME_NONE,
      !rsp_found && rsp_key_id == KEY_NOT_FOUND)

endmodule

`default_nettype wire

// ----- verif/tb_keyed_secret_table.sv -----
// Self-checking testbench for the keyed secret table with a behavioral table predictor.
`timescale 1ns / 1ps

module tb_keyed_secret_table;
   import kst_pkg::*;

   // One request as offered on the req_ channel.
   typedef struct {
      logic [KIND_BITS-1:0]       kind;
      logic [ID_PORT_BITS-1:0]    client_id;
      logic [ID_PORT_BITS-1:0]    server_id;
      logic signed [KEY_BITS-1:0] key_id;
      logic [STATUS_BITS-1:0]     status;
      logic [DATA_PORT_BITS-1:0]  key_data;
   } lookup_req_type;

   // One response as seen on the rsp_ channel.
   typedef struct {
      logic                       found;
      logic signed [KEY_BITS-1:0] key_id;
      logic [STATUS_BITS-1:0]     key_status;
      logic [DATA_PORT_BITS-1:0]  key_data;
      logic [OUTCOME_BITS-1:0]    outcome;
      logic [SLOT_BITS-1:0]       slot;
   } lookup_rsp_type;

   localparam logic [ID_PORT_BITS-1:0] ID_ALL_ONES = '1;
   localparam int POOL_SIZE = 32;
   // The response that starts the long hold-off on the response side.
   localparam int HOLD_AT = 50;
   localparam int HOLD_CYCLES = 1500;
   // Longest single operation is a full walk of 64 entries.
   localparam int SETTLE_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [KIND_BITS-1:0]       req_kind = KIND_WRITE;
   logic [ID_PORT_BITS-1:0]    req_client_id = '0;
   logic [ID_PORT_BITS-1:0]    req_server_id = '0;
   logic signed [KEY_BITS-1:0] req_new_key_id = '0;
   logic [STATUS_BITS-1:0]     req_new_status = '0;
   logic [DATA_PORT_BITS-1:0]  req_new_key_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_found;
   logic signed [KEY_BITS-1:0] rsp_key_id;
   logic [STATUS_BITS-1:0]     rsp_key_status;
   logic [DATA_PORT_BITS-1:0]  rsp_key_data;
   logic [OUTCOME_BITS-1:0]    rsp_write_outcome;
   logic [SLOT_BITS-1:0]       rsp_slot;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CFG_BITS-1:0]        csr_entries_in_use = CFG_RESET;

   // Predictor copy of the table and of the entries_in_use register.
   logic [ID_PORT_BITS-1:0]   t_client [TABLE_DEPTH];
   logic [ID_PORT_BITS-1:0]   t_server [TABLE_DEPTH];
   logic [KEY_BITS-1:0]       t_key    [TABLE_DEPTH];
   logic [STATUS_BITS-1:0]    t_status [TABLE_DEPTH];
   logic [DATA_PORT_BITS-1:0] t_data   [TABLE_DEPTH];
   logic [CFG_BITS-1:0]       entries_in_use_m = CFG_RESET;

   // Identifiers that random requests reuse so that updates and read hits happen.
   logic [ID_PORT_BITS-1:0] id_pool [POOL_SIZE];

   lookup_req_type requests_todo[$];
   lookup_rsp_type replies_due[$];
   lookup_req_type in_flight;

   int requests_queued = 0;
   int requests_taken = 0;
   int responses_seen = 0;
   int mismatches = 0;
   int send_wait = 0;
   int send_calm = 0;
   int recv_wait = 0;
   int recv_calm = 0;
   int hold_left = 0;

   keyed_secret_table uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_client_id     (req_client_id),
      .req_server_id     (req_server_id),
      .req_new_key_id    (req_new_key_id),
      .req_new_status    (req_new_status),
      .req_new_key_data  (req_new_key_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_key_id        (rsp_key_id),
      .rsp_key_status    (rsp_key_status),
      .rsp_key_data      (rsp_key_data),
      .rsp_write_outcome (rsp_write_outcome),
      .rsp_slot          (rsp_slot),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_entries_in_use(csr_entries_in_use)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Applies one request to the predictor table and returns the response it owes.
   function automatic lookup_rsp_type table_reply(lookup_req_type r);
      lookup_rsp_type res;
      int n;
      int hit;
      res.found = 1'b0;
      res.key_id = KEY_NOT_FOUND;
      res.key_status = '0;
      res.key_data = '0;
      res.outcome = OUTCOME_NONE;
      res.slot = '0;
      // Register values above the table depth search the whole table.
      n = (entries_in_use_m > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use_m);
      hit = -1;
      case (r.kind)
         KIND_WRITE: begin
            // An update only matches a stored pair with both ids present.
            for (int i = 0; i < n; i++) begin
               if (hit < 0 && t_client[i] != 0 && t_server[i] != 0 &&
                   t_client[i] == r.client_id && t_server[i] == r.server_id) begin
                  hit = i;
                  res.outcome = OUTCOME_UPDATED;
               end
            end
            for (int i = 0; i < n; i++) begin
               if (hit < 0 && t_client[i] == 0 && t_server[i] == 0) begin
                  hit = i;
                  res.outcome = OUTCOME_FILLED;
               end
            end
            // A full table gives up its last entry in use; with none in use nothing is stored.
            if (hit < 0 && n > 0) begin
               hit = n - 1;
               res.outcome = OUTCOME_OVERWROTE;
            end
            if (hit >= 0) begin
               t_client[hit] = r.client_id;
               t_server[hit] = r.server_id;
               t_key[hit] = r.key_id;
               t_status[hit] = r.status;
               t_data[hit] = r.key_data;
               res.slot = SLOT_BITS'(hit);
            end
         end
         KIND_READ: begin
            // A read with an empty id never searches.
            if (r.client_id != 0 && r.server_id != 0) begin
               for (int i = 0; i < n; i++) begin
                  if (hit < 0 && t_client[i] == r.client_id && t_server[i] == r.server_id &&
                      t_status[i] == STATUS_USABLE) begin
                     hit = i;
                     res.found = 1'b1;
                     res.key_id = t_key[i];
                     res.key_status = t_status[i];
                     res.key_data = t_data[i];
                     res.slot = SLOT_BITS'(i);
                  end
               end
            end
         end
         KIND_CLEAR: begin
            // A clear empties every entry, not only those in use.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               t_client[i] = '0;
               t_server[i] = '0;
               t_key[i] = '0;
               t_status[i] = '0;
               t_data[i] = '0;
            end
         end
         default: begin
            // The unused kind leaves the table alone and answers like a clear.
         end
      endcase
      return res;
   endfunction

   // Per-request wait, with runs of back-to-back requests now and then.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic lookup_req_type mk_req(logic [KIND_BITS-1:0] kind,
                                             logic [ID_PORT_BITS-1:0] cid,
                                             logic [ID_PORT_BITS-1:0] sid,
                                             logic [KEY_BITS-1:0] key,
                                             logic [STATUS_BITS-1:0] st,
                                             logic [DATA_PORT_BITS-1:0] data);
      lookup_req_type r;
      r.kind = kind;
      r.client_id = cid;
      r.server_id = sid;
      r.key_id = key;
      r.status = st;
      r.key_data = data;
      return r;
   endfunction

   // Mostly ids from a small pool, sometimes empty, sometimes fully random.
   function automatic logic [ID_PORT_BITS-1:0] pick_id(int pool);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return '0;
      if (roll < 8) return {$urandom, $urandom};
      return id_pool[$urandom_range(0, pool - 1)];
   endfunction

   function automatic lookup_req_type random_request(int pool, int clear_pct);
      lookup_req_type r;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) r.kind = KIND_CLEAR;
      else if (roll < clear_pct + 2) r.kind = KIND_NONE;
      else if (roll < 55) r.kind = KIND_WRITE;
      else r.kind = KIND_READ;
      r.client_id = pick_id(pool);
      r.server_id = pick_id(pool);
      r.key_id = $urandom;
      // Most records are usable so that reads can hit them.
      r.status = ($urandom_range(0, 3) != 0) ? STATUS_USABLE : STATUS_BITS'($urandom);
      r.key_data = {$urandom, $urandom};
      return r;
   endfunction

   task automatic queue_request(lookup_req_type r);
      requests_todo.push_back(r);
      requests_queued++;
   endtask

   // Returns once every queued request has been taken and answered.
   task automatic drain;
      do @(posedge clock);
      while (requests_taken != requests_queued || replies_due.size() != 0);
   endtask

   // Register writes are only issued while the block is idle.
   task automatic set_limit(logic [CFG_BITS-1:0] v);
      @(posedge clock);
      csr_entries_in_use <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      entries_in_use_m = v;
   endtask

   task automatic run_phase(int count, int pool, int clear_pct);
      for (int i = 0; i < count; i++) queue_request(random_request(pool, clear_pct));
      drain();
   endtask

   // Request driver: holds each request until it is taken, then waits its drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            replies_due.push_back(table_reply(in_flight));
            requests_taken++;
            send_wait = draw_wait(send_calm);
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (requests_todo.size() != 0) begin
               in_flight = requests_todo.pop_front();
               req_kind <= in_flight.kind;
               req_client_id <= in_flight.client_id;
               req_server_id <= in_flight.server_id;
               req_new_key_id <= in_flight.key_id;
               req_new_status <= in_flight.status;
               req_new_key_data <= in_flight.key_data;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each response against the oldest one owed and
   // throttles rsp_ready, once with a long hold-off that backs up the request side.
   always @(posedge clock) begin
      lookup_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $error("unexpected response: found %0d key_id %0d slot %0d",
                      rsp_found, rsp_key_id, rsp_slot);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  mismatches++;
               end
               if (rsp_key_id !== want.key_id) begin
                  $error("key_id: expected %0d, got %0d", want.key_id, rsp_key_id);
                  mismatches++;
               end
               if (rsp_key_status !== want.key_status) begin
                  $error("key_status: expected %0d, got %0d", want.key_status, rsp_key_status);
                  mismatches++;
               end
               if (rsp_key_data !== want.key_data) begin
                  $error("key_data: expected %h, got %h", want.key_data, rsp_key_data);
                  mismatches++;
               end
               if (rsp_write_outcome !== want.outcome) begin
                  $error("write_outcome: expected %0d, got %0d", want.outcome,
                         rsp_write_outcome);
                  mismatches++;
               end
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  mismatches++;
               end
            end
            responses_seen++;
            if (responses_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            else recv_wait = draw_wait(recv_calm);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus: directed requests at the reset setting and at settings 1 and 0, then
   // random phases across several entries_in_use settings, including 127 and 65.
   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         t_client[i] = '0;
         t_server[i] = '0;
         t_key[i] = '0;
         t_status[i] = '0;
         t_data[i] = '0;
      end
      id_pool[0] = ID_ALL_ONES;
      for (int i = 1; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom} | 64'd1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reads against the empty table, including ones with an empty id.
      queue_request(mk_req(KIND_READ, 64'h1111, 64'h2222, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_READ, 64'd0, ID_ALL_ONES, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_READ, ID_ALL_ONES, 64'd0, 32'd0, 8'd0, 64'd0));
      // Two records at the field extremes fill the first two entries.
      queue_request(mk_req(KIND_WRITE, ID_ALL_ONES, 64'd1, 32'h8000_0000, STATUS_USABLE,
                           ID_ALL_ONES));
      queue_request(mk_req(KIND_WRITE, 64'd1, ID_ALL_ONES, 32'h7FFF_FFFF, STATUS_USABLE,
                           64'd0));
      queue_request(mk_req(KIND_READ, ID_ALL_ONES, 64'd1, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_READ, 64'd1, ID_ALL_ONES, 32'd0, 8'd0, 64'd0));
      // Update in place to an unusable status, which hides the record from reads.
      queue_request(mk_req(KIND_WRITE, ID_ALL_ONES, 64'd1, 32'd5, 8'd0,
                           64'h5555_5555_5555_5555));
      queue_request(mk_req(KIND_READ, ID_ALL_ONES, 64'd1, 32'd0, 8'd0, 64'd0));
      // Records with an empty id are stored but can never match.
      queue_request(mk_req(KIND_WRITE, 64'd0, 64'h5, 32'd9, STATUS_USABLE, 64'h9));
      queue_request(mk_req(KIND_READ, 64'd0, 64'h5, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_WRITE, 64'd0, 64'd0, 32'd3, STATUS_USABLE, 64'h3));
      // The entry written with both ids empty still counts as free.
      queue_request(mk_req(KIND_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                           32'hFFFF_FFFF, 8'hFF, 64'hAAAA_AAAA_AAAA_AAAA));
      queue_request(mk_req(KIND_READ, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                           32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_WRITE, ID_ALL_ONES, 64'd1, 32'd77, STATUS_USABLE, 64'hA5));
      queue_request(mk_req(KIND_READ, ID_ALL_ONES, 64'd1, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_NONE, ID_ALL_ONES, ID_ALL_ONES, 32'hFFFF_FFFF, 8'hFF,
                           ID_ALL_ONES));
      queue_request(mk_req(KIND_CLEAR, 64'd0, 64'd0, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_READ, 64'd1, ID_ALL_ONES, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_WRITE, 64'd1, ID_ALL_ONES, 32'd42, STATUS_USABLE, 64'h42));
      queue_request(mk_req(KIND_READ, 64'd1, ID_ALL_ONES, 32'd0, 8'd0, 64'd0));
      drain();

      // A single entry in use: the second write overwrites the first.
      set_limit(7'd1);
      queue_request(mk_req(KIND_WRITE, 64'h10, 64'h20, 32'd1, STATUS_USABLE, 64'h1));
      queue_request(mk_req(KIND_WRITE, 64'h30, 64'h40, 32'd2, STATUS_USABLE, 64'h2));
      queue_request(mk_req(KIND_READ, 64'h30, 64'h40, 32'd0, 8'd0, 64'd0));
      queue_request(mk_req(KIND_READ, 64'h10, 64'h20, 32'd0, 8'd0, 64'd0));
      drain();

      // No entries in use: writes store nothing and reads find nothing.
      set_limit(7'd0);
      queue_request(mk_req(KIND_WRITE, 64'h50, 64'h60, 32'd3, STATUS_USABLE, 64'h3));
      queue_request(mk_req(KIND_READ, 64'h30, 64'h40, 32'd0, 8'd0, 64'd0));
      drain();

      // Saturated setting with a wide id pool and no clears, so the whole
      // table fills and the last entry gets overwritten. The long response
      // hold-off falls in this phase.
      set_limit(7'd127);
      run_phase(120, 16, 0);
      set_limit(7'd4);
      run_phase(80, 6, 3);
      set_limit(7'd65);
      run_phase(50, 8, 3);
      set_limit(7'd1);
      run_phase(30, 4, 3);
      set_limit(CFG_BITS'($urandom_range(2, 63)));
      run_phase(60, 8, 4);
      set_limit(7'd64);
      run_phase(60, 8, 3);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_keyed_secret_table OK");
      end else begin
         $display("tb_keyed_secret_table NOT OK");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("tb_keyed_secret_table NOT OK");
      $finish;
   end

endmodule
